// ===== rtl/ssr_pkg.sv =====
// Shared types, constants and per-axis arithmetic for the servo slew ramp.
// Used by servo_slew_ramp_unit and by its port checker; depends on nothing.
package ssr_pkg;

  localparam int NUM_LEGS = 4;
  localparam int NUM_AXES = 2 * NUM_LEGS;
  localparam int POS_W    = 8;
  localparam int SPD_W    = 4;
  localparam int TRIM_W   = 5;
  localparam int HEIGHT_W = 6;
  localparam int DELAY_W  = 6;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  localparam logic [POS_W-1:0]           POS_RESET    = POS_W'(90);
  localparam logic [TRIM_W-1:0]          TRIM_RESET   = TRIM_W'(15);
  localparam logic signed [HEIGHT_W-1:0] HEIGHT_RESET = '0;
  localparam logic [DELAY_W-1:0]         DELAY_RESET  = DELAY_W'(10);

  typedef enum logic [1:0] {
    REG_PIVOT_TRIM,
    REG_STAND_HEIGHT,
    REG_STEP_DELAY
  } reg_idx_e;

  // Saturate a signed intermediate to the servo range 0..255.
  function automatic logic [POS_W-1:0] sat_pos(input logic signed [POS_W+1:0] v);
    logic [POS_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed((POS_W+2)'(255))) begin
      r = '1;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  // Pivot target: trim is added on back-left and front-right, subtracted elsewhere.
  function automatic logic [POS_W-1:0] pivot_target(input logic [POS_W-1:0] raw,
                                                    input logic [TRIM_W-1:0] trim,
                                                    input logic add_trim);
    logic signed [POS_W+1:0] s;
    if (add_trim) begin
      s = $signed({2'b00, raw}) + $signed({{(POS_W+2-TRIM_W){1'b0}}, trim});
    end else begin
      s = $signed({2'b00, raw}) - $signed({{(POS_W+2-TRIM_W){1'b0}}, trim});
    end
    return sat_pos(s);
  endfunction

  function automatic logic [POS_W-1:0] lift_target(input logic [POS_W-1:0] raw,
                                                   input logic signed [HEIGHT_W-1:0] height);
    logic signed [POS_W+1:0] s;
    s = $signed({2'b00, raw}) + $signed({{(POS_W+2-HEIGHT_W){height[HEIGHT_W-1]}}, height});
    return sat_pos(s);
  endfunction

  // One slew step toward the target, clamped so that it never overshoots.
  function automatic logic [POS_W-1:0] axis_step(input logic [POS_W-1:0] pos,
                                                 input logic [POS_W-1:0] tgt,
                                                 input logic [SPD_W-1:0] spd);
    logic [POS_W:0]   up;
    logic [POS_W:0]   dn;
    logic [POS_W-1:0] r;
    up = {1'b0, pos} + {{(POS_W+1-SPD_W){1'b0}}, spd};
    dn = {1'b0, pos} - {{(POS_W+1-SPD_W){1'b0}}, spd};
    if (pos < tgt) begin
      r = (up > {1'b0, tgt}) ? tgt : up[POS_W-1:0];
    end else if (pos > tgt) begin
      r = (dn[POS_W] || (dn[POS_W-1:0] < tgt)) ? tgt : dn[POS_W-1:0];
    end else begin
      r = pos;
    end
    return r;
  endfunction

endpackage

// ===== rtl/servo_slew_ramp_unit.sv =====
// Top level of the eight-axis servo slew ramp: keyframe targets, per-leg slew and step timer.
// Depends on ssr_pkg for constants, register indexes and the per-axis arithmetic.
//
//   Channel   Direction  Handshake                 Carries
//   in        in         in_valid_i / in_stall_o   mode, eight raw angles, leg_speeds
//   out       out        out_valid_o / out_stall_i eight positions, busy_res, stepped
//   config    in         APB psel/penable/pwrite   pivot_trim, stand_height, step_delay_ms
//
// The state and the result register are written at the edge that accepts an item, and its
// result is offered in the next cycle. One item is accepted per cycle while the input is not stalled.
// The input stalls only while a finished result is held by a stall on the output.
// Reset sets every axis and target to 90, speeds and the step timer to zero and the
// registers to their defaults; no clearing pass follows.
module servo_slew_ramp_unit import ssr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                mode_i,
  input  logic [POS_W-1:0]    front_left_pivot_i,
  input  logic [POS_W-1:0]    back_left_pivot_i,
  input  logic [POS_W-1:0]    back_right_pivot_i,
  input  logic [POS_W-1:0]    front_right_pivot_i,
  input  logic [POS_W-1:0]    front_left_lift_i,
  input  logic [POS_W-1:0]    back_left_lift_i,
  input  logic [POS_W-1:0]    back_right_lift_i,
  input  logic [POS_W-1:0]    front_right_lift_i,
  input  logic [NUM_LEGS*SPD_W-1:0] leg_speeds_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [POS_W-1:0]    pos_front_left_pivot_o,
  output logic [POS_W-1:0]    pos_back_left_pivot_o,
  output logic [POS_W-1:0]    pos_back_right_pivot_o,
  output logic [POS_W-1:0]    pos_front_right_pivot_o,
  output logic [POS_W-1:0]    pos_front_left_lift_o,
  output logic [POS_W-1:0]    pos_back_left_lift_o,
  output logic [POS_W-1:0]    pos_back_right_lift_o,
  output logic [POS_W-1:0]    pos_front_right_lift_o,
  output logic                busy_res_o,
  output logic                stepped_o
);

  logic [TRIM_W-1:0]          trim_q;
  logic signed [HEIGHT_W-1:0] height_q;
  logic [DELAY_W-1:0]         delay_cfg_q;

  logic [POS_W-1:0] pos_q [NUM_AXES];
  logic [POS_W-1:0] pos_d [NUM_AXES];
  logic [POS_W-1:0] tgt_q [NUM_AXES];
  logic [POS_W-1:0] tgt_d [NUM_AXES];
  logic [SPD_W-1:0] spd_q [NUM_LEGS];
  logic [SPD_W-1:0] spd_d [NUM_LEGS];
  logic [DELAY_W-1:0] delay_q;
  logic [DELAY_W-1:0] delay_d;
  logic               out_valid_q;
  logic               out_valid_d;
  logic               busy_q;
  logic               busy_d;
  logic               stepped_q;
  logic               stepped_d;

  logic [POS_W-1:0]   raw_pivot [NUM_LEGS];
  logic [POS_W-1:0]   raw_lift [NUM_LEGS];
  logic               in_accept;
  logic               cfg_write;
  logic               is_load;
  logic               off_now;
  logic               do_step;
  logic [DELAY_W-1:0] delay_dec;

  assign pready     = 1'b1;
  assign cfg_write  = psel && penable && pwrite && pready;
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign is_load    = !mode_i;

  assign raw_pivot[0] = front_left_pivot_i;
  assign raw_pivot[1] = back_left_pivot_i;
  assign raw_pivot[2] = back_right_pivot_i;
  assign raw_pivot[3] = front_right_pivot_i;
  assign raw_lift[0]  = front_left_lift_i;
  assign raw_lift[1]  = back_left_lift_i;
  assign raw_lift[2]  = back_right_lift_i;
  assign raw_lift[3]  = front_right_lift_i;

  // A load replaces targets and speeds first; the step then works on the new targets.
  always_comb begin
    for (int l = 0; l < NUM_LEGS; l++) begin
      if (is_load) begin
        tgt_d[l]            = pivot_target(raw_pivot[l], trim_q, l[0]);
        tgt_d[NUM_LEGS + l] = lift_target(raw_lift[l], height_q);
        spd_d[l]            = leg_speeds_i[SPD_W*l +: SPD_W];
      end else begin
        tgt_d[l]            = tgt_q[l];
        tgt_d[NUM_LEGS + l] = tgt_q[NUM_LEGS + l];
        spd_d[l]            = spd_q[l];
      end
    end
  end

  always_comb begin
    off_now   = 1'b0;
    for (int a = 0; a < NUM_AXES; a++) begin
      off_now = off_now || (pos_q[a] != tgt_d[a]);
    end
    delay_dec = (delay_q != '0) ? delay_q - DELAY_W'(1) : '0;
    do_step   = off_now && (is_load || (delay_dec == '0));

    for (int a = 0; a < NUM_AXES; a++) begin
      pos_d[a] = do_step ? axis_step(pos_q[a], tgt_d[a], spd_d[a % NUM_LEGS]) : pos_q[a];
    end

    if (do_step) begin
      delay_d = delay_cfg_q;
    end else if (is_load) begin
      delay_d = '0;
    end else begin
      delay_d = delay_dec;
    end

    busy_d    = (delay_d != '0);
    stepped_d = 1'b0;
    for (int a = 0; a < NUM_AXES; a++) begin
      busy_d    = busy_d || (pos_d[a] != tgt_d[a]);
      stepped_d = stepped_d || (pos_d[a] != pos_q[a]);
    end

    if (in_accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      delay_q     <= '0;
      for (int a = 0; a < NUM_AXES; a++) begin
        pos_q[a] <= POS_RESET;
        tgt_q[a] <= POS_RESET;
      end
      for (int l = 0; l < NUM_LEGS; l++) begin
        spd_q[l] <= '0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      if (in_accept) begin
        delay_q <= delay_d;
        pos_q   <= pos_d;
        tgt_q   <= tgt_d;
        spd_q   <= spd_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      busy_q    <= busy_d;
      stepped_q <= stepped_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trim_q      <= TRIM_RESET;
      height_q    <= HEIGHT_RESET;
      delay_cfg_q <= DELAY_RESET;
    end else if (cfg_write) begin
      case (reg_idx_e'(paddr[3:2]))
        REG_PIVOT_TRIM: begin
          trim_q <= pwdata[TRIM_W-1:0];
        end
        REG_STAND_HEIGHT: begin
          height_q <= $signed(pwdata[HEIGHT_W-1:0]);
        end
        REG_STEP_DELAY: begin
          delay_cfg_q <= pwdata[DELAY_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[3:2]))
      REG_PIVOT_TRIM:   prdata = {{(DATA_W-TRIM_W){1'b0}}, trim_q};
      REG_STAND_HEIGHT: prdata = {{(DATA_W-HEIGHT_W){height_q[HEIGHT_W-1]}}, height_q};
      REG_STEP_DELAY:   prdata = {{(DATA_W-DELAY_W){1'b0}}, delay_cfg_q};
      default:          prdata = '0;
    endcase
  end

  assign out_valid_o             = out_valid_q;
  assign pos_front_left_pivot_o  = pos_q[0];
  assign pos_back_left_pivot_o   = pos_q[1];
  assign pos_back_right_pivot_o  = pos_q[2];
  assign pos_front_right_pivot_o = pos_q[3];
  assign pos_front_left_lift_o   = pos_q[4];
  assign pos_back_left_lift_o    = pos_q[5];
  assign pos_back_right_lift_o   = pos_q[6];
  assign pos_front_right_lift_o  = pos_q[7];
  assign busy_res_o              = busy_q;
  assign stepped_o               = stepped_q;

endmodule

// ===== rtl/ssr_checker.sv =====
// Port checker for servo_slew_ramp_unit, attached to it by the bind statement below.
// Depends on ssr_pkg for widths and the reset position.
module ssr_checker import ssr_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                psel,
  input logic                penable,
  input logic                pwrite,
  input logic [ADDR_W-1:0]   paddr,
  input logic [DATA_W-1:0]   pwdata,
  input logic [DATA_W-1:0]   prdata,
  input logic                pready,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                mode_i,
  input logic [POS_W-1:0]    front_left_pivot_i,
  input logic [POS_W-1:0]    back_left_pivot_i,
  input logic [POS_W-1:0]    back_right_pivot_i,
  input logic [POS_W-1:0]    front_right_pivot_i,
  input logic [POS_W-1:0]    front_left_lift_i,
  input logic [POS_W-1:0]    back_left_lift_i,
  input logic [POS_W-1:0]    back_right_lift_i,
  input logic [POS_W-1:0]    front_right_lift_i,
  input logic [NUM_LEGS*SPD_W-1:0] leg_speeds_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [POS_W-1:0]    pos_front_left_pivot_o,
  input logic [POS_W-1:0]    pos_back_left_pivot_o,
  input logic [POS_W-1:0]    pos_back_right_pivot_o,
  input logic [POS_W-1:0]    pos_front_right_pivot_o,
  input logic [POS_W-1:0]    pos_front_left_lift_o,
  input logic [POS_W-1:0]    pos_back_left_lift_o,
  input logic [POS_W-1:0]    pos_back_right_lift_o,
  input logic [POS_W-1:0]    pos_front_right_lift_o,
  input logic                busy_res_o,
  input logic                stepped_o
);

  logic [NUM_AXES*POS_W-1:0] pos_bus;
  logic [NUM_AXES*POS_W-1:0] last_pos_q;
  logic [NUM_AXES*POS_W+1:0] result_bus;
  logic                      in_accept;
  logic                      out_accept;

  assign pos_bus = {pos_front_left_pivot_o, pos_back_left_pivot_o, pos_back_right_pivot_o,
                    pos_front_right_pivot_o, pos_front_left_lift_o, pos_back_left_lift_o,
                    pos_back_right_lift_o, pos_front_right_lift_o};
  assign result_bus = {pos_bus, busy_res_o, stepped_o};
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_accept = out_valid_o && !out_stall_i;

  // Positions of the last delivered item, starting from the reset pose.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pos_q <= {NUM_AXES{POS_RESET}};
    end else if (out_accept) begin
      last_pos_q <= pos_bus;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_bus))
    else $error("stalled result changed");

  a_stall_only_on_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  a_item_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_o)
    else $error("accepted item produced no result");

  a_stepped_matches_motion: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (stepped_o == (pos_bus != last_pos_q)))
    else $error("stepped flag disagrees with position change");

endmodule

bind servo_slew_ramp_unit ssr_checker u_ssr_checker (.*);

// ===== tb/tb_servo_slew_ramp_unit.sv =====
// Self-checking testbench for servo_slew_ramp_unit: directed keyframes, then random ramps.
// Keeps its own ramp predictor and checks every output item; needs only ssr_pkg and the RTL.
`timescale 1ns / 100ps

module tb_servo_slew_ramp_unit;
  import ssr_pkg::*;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_TICK   = 1'b1;
  localparam int   STALL_LIMIT = 2000;
  localparam int   HOLD_CYCLES = 300;
  localparam int   TAIL_CYCLES = 8;
  localparam int   CHUNK_ITEMS = 220;

  typedef struct packed {
    logic                             mode;
    logic [NUM_AXES-1:0][POS_W-1:0]   angle;
    logic [NUM_LEGS*SPD_W-1:0]        speeds;
  } keyframe_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][POS_W-1:0] pos;
    logic                           busy;
    logic                           stepped;
  } pose_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [ADDR_W-1:0]              paddr = '0;
  logic [DATA_W-1:0]              pwdata = '0;
  logic [DATA_W-1:0]              prdata;
  logic                           pready;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  logic                           drv_mode = MODE_TICK;
  logic [NUM_AXES-1:0][POS_W-1:0] drv_angle = '0;
  logic [NUM_LEGS*SPD_W-1:0]      drv_speeds = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [NUM_AXES-1:0][POS_W-1:0] dut_pos;
  logic                           busy_res_o;
  logic                           stepped_o;

  logic [POS_W-1:0]               pos_front_left_pivot_o, pos_back_left_pivot_o;
  logic [POS_W-1:0]               pos_back_right_pivot_o, pos_front_right_pivot_o;
  logic [POS_W-1:0]               pos_front_left_lift_o, pos_back_left_lift_o;
  logic [POS_W-1:0]               pos_back_right_lift_o, pos_front_right_lift_o;

  assign dut_pos = {pos_front_right_lift_o, pos_back_right_lift_o, pos_back_left_lift_o,
                    pos_front_left_lift_o, pos_front_right_pivot_o, pos_back_right_pivot_o,
                    pos_back_left_pivot_o, pos_front_left_pivot_o};

  // Predictor state.
  logic [POS_W-1:0]           cur_pos [NUM_AXES];
  logic [POS_W-1:0]           aim [NUM_AXES];
  logic [SPD_W-1:0]           leg_spd [NUM_LEGS];
  int                         wait_cnt;
  logic [TRIM_W-1:0]          cfg_trim;
  logic signed [HEIGHT_W-1:0] cfg_height;
  logic [DELAY_W-1:0]         cfg_delay;
  bit                         ramp_busy;

  pose_t expected_poses[$];
  int    mismatch_cnt = 0;
  int    quiet_cycles = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  int    hold_req = 0;
  int    hold_left = 0;

  string axis_name [NUM_AXES] = '{"front_left_pivot", "back_left_pivot", "back_right_pivot",
                                  "front_right_pivot", "front_left_lift", "back_left_lift",
                                  "back_right_lift", "front_right_lift"};

  servo_slew_ramp_unit dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .psel                   (psel),
    .penable                (penable),
    .pwrite                 (pwrite),
    .paddr                  (paddr),
    .pwdata                 (pwdata),
    .prdata                 (prdata),
    .pready                 (pready),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .mode_i                 (drv_mode),
    .front_left_pivot_i     (drv_angle[0]),
    .back_left_pivot_i      (drv_angle[1]),
    .back_right_pivot_i     (drv_angle[2]),
    .front_right_pivot_i    (drv_angle[3]),
    .front_left_lift_i      (drv_angle[4]),
    .back_left_lift_i       (drv_angle[5]),
    .back_right_lift_i      (drv_angle[6]),
    .front_right_lift_i     (drv_angle[7]),
    .leg_speeds_i           (drv_speeds),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .pos_front_left_pivot_o (pos_front_left_pivot_o),
    .pos_back_left_pivot_o  (pos_back_left_pivot_o),
    .pos_back_right_pivot_o (pos_back_right_pivot_o),
    .pos_front_right_pivot_o(pos_front_right_pivot_o),
    .pos_front_left_lift_o  (pos_front_left_lift_o),
    .pos_back_left_lift_o   (pos_back_left_lift_o),
    .pos_back_right_lift_o  (pos_back_right_lift_o),
    .pos_front_right_lift_o (pos_front_right_lift_o),
    .busy_res_o             (busy_res_o),
    .stepped_o              (stepped_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [POS_W-1:0] sat_angle(int v);
    if (v < 0) return '0;
    if (v > 255) return '1;
    return POS_W'(v);
  endfunction

  function automatic bit off_aim();
    for (int i = 0; i < NUM_AXES; i++) begin
      if (cur_pos[i] != aim[i]) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void slew_all();
    int p;
    int t;
    int s;
    for (int i = 0; i < NUM_AXES; i++) begin
      p = cur_pos[i];
      t = aim[i];
      s = leg_spd[i % NUM_LEGS];
      if (p < t) begin
        p = (p + s > t) ? t : p + s;
      end else if (p > t) begin
        p = (p - s < t) ? t : p - s;
      end
      cur_pos[i] = POS_W'(p);
    end
    wait_cnt = int'(cfg_delay);
  endfunction

  function automatic pose_t ramp_predict(keyframe_t f);
    pose_t            r;
    logic [POS_W-1:0] prev [NUM_AXES];
    int               piv;
    prev = cur_pos;
    if (f.mode == MODE_LOAD) begin
      for (int i = 0; i < NUM_LEGS; i++) begin
        // Back left and front right get the trim added, the other two subtracted.
        piv = (i % 2 == 1) ? int'(f.angle[i]) + int'(cfg_trim)
                           : int'(f.angle[i]) - int'(cfg_trim);
        aim[i] = sat_angle(piv);
        aim[NUM_LEGS+i] = sat_angle(int'(f.angle[NUM_LEGS+i]) + int'(cfg_height));
        leg_spd[i] = f.speeds[SPD_W*i +: SPD_W];
      end
      wait_cnt = 0;
      if (off_aim()) slew_all();
    end else begin
      if (wait_cnt != 0) wait_cnt--;
      if (wait_cnt == 0 && off_aim()) slew_all();
    end
    r.stepped = 1'b0;
    for (int i = 0; i < NUM_AXES; i++) begin
      r.pos[i] = cur_pos[i];
      if (cur_pos[i] != prev[i]) r.stepped = 1'b1;
    end
    r.busy = off_aim() || wait_cnt != 0;
    ramp_busy = r.busy;
    return r;
  endfunction

  function automatic keyframe_t rand_frame(logic mode, bit wild);
    keyframe_t f;
    f.mode = mode;
    for (int i = 0; i < NUM_AXES; i++) begin
      if (wild || $urandom_range(3) == 0) begin
        f.angle[i] = POS_W'($urandom_range(255));
      end else begin
        f.angle[i] = POS_W'(int'(cur_pos[i]) + int'($urandom_range(40)) - 20);
      end
    end
    if (wild) begin
      f.speeds = (NUM_LEGS*SPD_W)'($urandom_range(16'hFFFF));
    end else begin
      for (int i = 0; i < NUM_LEGS; i++) begin
        f.speeds[SPD_W*i +: SPD_W] = ($urandom_range(15) == 0) ? '0 :
                                     SPD_W'($urandom_range(15, 1));
      end
    end
    return f;
  endfunction

  function automatic keyframe_t flat_frame(logic [POS_W-1:0] ang, logic [15:0] spd);
    keyframe_t f;
    f.mode = MODE_LOAD;
    for (int i = 0; i < NUM_AXES; i++) f.angle[i] = ang;
    f.speeds = spd;
    return f;
  endfunction

  task automatic report_mismatch(string what, int want, int got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    end
  endtask

  // Output checker: every accepted item is compared with the oldest expected pose.
  always @(posedge clk_i) begin : pose_checker
    pose_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_poses.size() == 0) begin
        report_mismatch("unexpected output item", 0, 1);
      end else begin
        want = expected_poses.pop_front();
        for (int i = 0; i < NUM_AXES; i++) begin
          if (dut_pos[i] !== want.pos[i]) begin
            report_mismatch(axis_name[i], int'(want.pos[i]), int'(dut_pos[i]));
          end
        end
        if (busy_res_o !== want.busy) begin
          report_mismatch("busy_res", int'(want.busy), int'(busy_res_o));
        end
        if (stepped_o !== want.stepped) begin
          report_mismatch("stepped", int'(want.stepped), int'(stepped_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(keyframe_t f);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    drv_mode   <= f.mode;
    drv_angle  <= f.angle;
    drv_speeds <= f.speeds;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_poses.push_back(ramp_predict(f));
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_item(rand_frame(MODE_TICK, 1'b1));
  endtask

  task automatic wait_drain();
    while (expected_poses.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_write(reg_idx_e idx, int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * idx);
    pwdata  <= DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_PIVOT_TRIM:   cfg_trim = pwdata[TRIM_W-1:0];
      REG_STAND_HEIGHT: cfg_height = pwdata[HEIGHT_W-1:0];
      REG_STEP_DELAY:   cfg_delay = pwdata[DELAY_W-1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_setting(int trim, int height, int delay);
    in_valid_i <= 1'b0;
    wait_drain();
    apb_write(REG_PIVOT_TRIM, trim);
    apb_write(REG_STAND_HEIGHT, height);
    apb_write(REG_STEP_DELAY, delay);
  endtask

  task automatic test_idle_after_reset();
    send_ticks(1);
  endtask

  // Full-range keyframes, a zero delay, and a reload that is already on target.
  task automatic test_keyframe_extremes();
    send_item(flat_frame('0, 16'hFFFF));
    send_ticks(2);
    apply_setting(15, 0, 0);
    send_item(flat_frame('0, 16'hFFFF));
    send_ticks(5);
    send_item(flat_frame('0, 16'hFFFF));
    send_item(flat_frame('1, 16'hFFFF));
  endtask

  // A zero step size keeps its axes off target, and a load cuts into a running ramp.
  task automatic test_zero_speed_and_reload();
    send_item(flat_frame(8'd128, 16'h0000));
    send_ticks(2);
    send_item(flat_frame(8'd200, 16'h1248));
    send_ticks(3);
  endtask

  task automatic test_random_ramps(int trim, int height, int delay);
    int sent;
    int run_len;
    bit settle;
    apply_setting(trim, height, delay);
    sent = 0;
    while (sent < CHUNK_ITEMS) begin
      send_item(rand_frame(MODE_LOAD, $urandom_range(3) == 0));
      sent++;
      run_len = $urandom_range(1, 4 * (int'(cfg_delay) + 1));
      settle = 1'($urandom_range(1));
      for (int k = 0; k < run_len || (settle && ramp_busy && k < 300); k++) begin
        send_item(rand_frame(MODE_TICK, 1'b1));
        sent++;
      end
    end
  endtask

  // The receiver holds off long enough for the input to stall, then the sender drains.
  task automatic test_output_holdoff();
    hold_req = HOLD_CYCLES;
    send_item(rand_frame(MODE_LOAD, 1'b0));
    send_ticks(40);
    in_valid_i <= 1'b0;
    wait_drain();
  endtask

  initial begin
    for (int i = 0; i < NUM_AXES; i++) begin
      cur_pos[i] = POS_RESET;
      aim[i] = POS_RESET;
    end
    for (int i = 0; i < NUM_LEGS; i++) leg_spd[i] = '0;
    wait_cnt   = 0;
    cfg_trim   = TRIM_RESET;
    cfg_height = HEIGHT_RESET;
    cfg_delay  = DELAY_RESET;
    ramp_busy  = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct  = 25;
    recv_stall_pct = 60;
    test_idle_after_reset();
    test_keyframe_extremes();
    test_zero_speed_and_reload();
    test_random_ramps(0, 0, 0);
    test_random_ramps(30, 30, 3);
    test_random_ramps(31, -32, 1);

    send_idle_pct  = 60;
    recv_stall_pct = 25;
    test_random_ramps(15, -30, 50);
    test_random_ramps(7, 31, 63);
    test_random_ramps(20, -5, 2);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_output_holdoff();
    test_random_ramps(0, -32, 5);
    test_random_ramps(31, 31, 10);
    test_random_ramps(12, 8, 4);

    in_valid_i <= 1'b0;
    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_poses.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ssr_pkg.sv
rtl/servo_slew_ramp_unit.sv
rtl/ssr_checker.sv
tb/tb_servo_slew_ramp_unit.sv
